// ===== rtl/nff_pkg.sv =====
// ----------------------------------------------------------------------------
// nff_pkg
// Shared types and constants of the nixie frame formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package nff_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_LIMIT  = 1'b0,
    REG_BLINK_PERIOD = 1'b1
  } cfg_index_t;

  localparam logic [31:0] FRAME_LIMIT_RESET  = 32'd5000;
  localparam logic [15:0] BLINK_PERIOD_RESET = 16'd300;

  // value / 1000 as multiply by reciprocal, exact for any 20-bit value
  localparam logic [20:0] DIV1000_RECIP = 21'd1073742;
  localparam int          DIV1000_SHIFT = 30;

  // frame layout
  localparam int          FRAME_BITS      = 64;
  localparam logic [2:0]  LAST_IDX_ON     = 3'd7;
  localparam logic [2:0]  LAST_IDX_OFF    = 3'd3;

  // one refresh request as it arrives
  typedef struct packed {
    logic [31:0] now_us;
    logic [31:0] now_ms;
    logic [19:0] display_value;
    logic        tubes_on;
    logic        blink_up;
    logic        blink_down;
    logic [7:0]  blink_mask;
    logic [7:0]  dot_pattern;
  } req_item_t;

  // one byte going to the tube drivers
  typedef struct packed {
    logic [7:0] spi_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic       raise_enable;
  } res_item_t;

  // request after the thousands split, held in the input register
  typedef struct packed {
    logic [31:0] now_us;
    logic [31:0] now_ms;
    logic [10:0] kilo;       // value / 1000
    logic [9:0]  low_bits;   // value mod 1024
    logic        tubes_on;
    logic        blinking;
    logic [7:0]  blink_mask;
    logic [7:0]  dot_pattern;
  } prep_t;

  // a formatted frame handed to the serialiser
  typedef struct packed {
    logic [63:0] data;
    logic        tubes_on;
  } frame_t;

endpackage

`default_nettype wire

// ===== rtl/nff_req_stage.sv =====
// ----------------------------------------------------------------------------
// nff_req_stage
// Input register: takes a request and splits the value into thousands.
// ----------------------------------------------------------------------------
`default_nettype none

module nff_req_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              request_valid,
  output      logic              request_stall,
  input  wire nff_pkg::req_item_t request,
  input  wire logic              take,
  output      logic              full,
  output      nff_pkg::prep_t    prep
);

  logic [40:0]    kilo_prod;
  nff_pkg::prep_t prep_next;
  logic           accept;

  // thousands by reciprocal multiply
  always_comb begin
    kilo_prod = 41'(request.display_value) * 41'(nff_pkg::DIV1000_RECIP);
    prep_next.now_us      = request.now_us;
    prep_next.now_ms      = request.now_ms;
    prep_next.kilo        = kilo_prod[nff_pkg::DIV1000_SHIFT +: 11];
    prep_next.low_bits    = request.display_value[9:0];
    prep_next.tubes_on    = request.tubes_on;
    prep_next.blinking    = request.blink_up & request.blink_down;
    prep_next.blink_mask  = request.blink_mask;
    prep_next.dot_pattern = request.dot_pattern;
  end

  assign request_stall = full & ~take;
  assign accept        = request_valid & ~request_stall;

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prep <= prep_next;
    end
  end

  // a held item is only released by the core
  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    take |-> full) else $error("item taken from empty input register");
  a_kilo_range: assert property (@(posedge clk) disable iff (rst)
    full |-> prep.kilo <= 11'd1048) else $error("thousands out of range");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    full && !take |=> full && $stable(prep)) else $error("held item lost");

endmodule

`default_nettype wire

// ===== rtl/nff_frame_core.sv =====
// ----------------------------------------------------------------------------
// nff_frame_core
// Frame limit check, blink state, digit split and one-hot word build.
// ----------------------------------------------------------------------------
`default_nettype none

module nff_frame_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  input  wire nff_pkg::cfg_index_t cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic                full,
  input  wire nff_pkg::prep_t      prep,
  input  wire logic                free,
  output      logic                take,
  output      logic                load,
  output      nff_pkg::frame_t     frame
);

  // split an 11-bit value into hundreds (mod 10), tens and units
  function automatic logic [11:0] split3(input logic [10:0] x);
    logic [15:0] hprod;
    logic [3:0]  h;
    logic [10:0] hx100;
    logic [6:0]  rest;
    logic [14:0] tprod;
    logic [3:0]  t;
    logic [6:0]  tx10;
    logic [3:0]  u;
    hprod = 16'(x) * 16'd41;
    h     = hprod[15:12];
    hx100 = 11'(h) * 11'd100;
    rest  = 7'(x - hx100);
    tprod = 15'(rest) * 15'd205;
    t     = tprod[14:11];
    tx10  = 7'(t) * 7'd10;
    u     = 4'(rest - tx10);
    if (h == 4'd10) begin
      h = 4'd0;
    end
    return {h, t, u};
  endfunction

  // configuration registers
  logic [31:0] frame_limit_us;
  logic [15:0] blink_period_ms;

  // state
  logic [31:0] last_frame_time;
  logic [31:0] last_blink_time;
  logic        blink_phase;
  logic [7:0]  dot_mask_hold;
  logic        lower_dot;
  logic        upper_dot;

  logic        drop;
  logic        toggle;
  logic        upd_blink;
  logic        blink_phase_next;
  logic [7:0]  dot_mask_hold_next;
  logic [7:0]  eff;
  logic        lower_dot_next;
  logic        upper_dot_next;
  logic [9:0]  kx1000;
  logic [9:0]  rem;
  logic [11:0] hi_dig;
  logic [11:0] lo_dig;
  logic [3:0]  dig [6];
  logic [9:0]  code [6];
  logic [31:0] w1;
  logic [31:0] w0;

  // frame limit check
  assign drop = (prep.now_us - last_frame_time) < frame_limit_us;
  assign take = full & (drop | free);
  assign load = full & ~drop & free;
  assign upd_blink = load & prep.tubes_on & prep.blinking;

  // blink phase and dot flags
  always_comb begin
    toggle = (prep.now_ms - last_blink_time) > {16'd0, blink_period_ms};
    blink_phase_next   = blink_phase;
    dot_mask_hold_next = dot_mask_hold;
    if (toggle) begin
      blink_phase_next   = ~blink_phase;
      dot_mask_hold_next = blink_phase ? prep.blink_mask : 8'd0;
    end
    eff            = prep.dot_pattern & ~dot_mask_hold_next;
    lower_dot_next = prep.blinking ? eff[6] : lower_dot;
    upper_dot_next = prep.blinking ? eff[7] : upper_dot;
  end

  // decimal digits, position 0 is hour tens
  always_comb begin
    kx1000 = 10'(prep.kilo * 11'd1000);
    rem    = prep.low_bits - kx1000;
    hi_dig = split3(prep.kilo);
    lo_dig = split3({1'b0, rem});
    dig[0] = hi_dig[11:8];
    dig[1] = hi_dig[7:4];
    dig[2] = hi_dig[3:0];
    dig[3] = lo_dig[11:8];
    dig[4] = lo_dig[7:4];
    dig[5] = lo_dig[3:0];
  end

  // one-hot codes with blanking
  always_comb begin
    for (int p = 0; p < 6; p++) begin
      if (prep.blinking && blink_phase_next && prep.blink_mask[p]) begin
        code[p] = 10'd0;
      end else begin
        code[p] = 10'd1 << dig[p];
      end
    end
    w1 = {upper_dot_next, lower_dot_next, code[5], code[4], code[3]};
    w0 = {upper_dot_next, lower_dot_next, code[2], code[1], code[0]};
    frame.tubes_on = prep.tubes_on;
    frame.data     = prep.tubes_on ? {w1, w0} : '0;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit_us  <= nff_pkg::FRAME_LIMIT_RESET;
      blink_period_ms <= nff_pkg::BLINK_PERIOD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        nff_pkg::REG_FRAME_LIMIT:  frame_limit_us  <= cfg_data;
        nff_pkg::REG_BLINK_PERIOD: blink_period_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // frame time
  always_ff @(posedge clk) begin
    if (rst) begin
      last_frame_time <= '0;
    end else if (load) begin
      last_frame_time <= prep.now_us;
    end
  end

  // blink state, only on a tubes-on frame with editing enabled
  always_ff @(posedge clk) begin
    if (rst) begin
      last_blink_time <= '0;
      blink_phase     <= 1'b0;
      dot_mask_hold   <= '0;
      lower_dot       <= 1'b0;
      upper_dot       <= 1'b0;
    end else if (upd_blink) begin
      if (toggle) begin
        last_blink_time <= prep.now_ms;
      end
      blink_phase   <= blink_phase_next;
      dot_mask_hold <= dot_mask_hold_next;
      lower_dot     <= lower_dot_next;
      upper_dot     <= upper_dot_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nff_byte_shifter.sv =====
// ----------------------------------------------------------------------------
// nff_byte_shifter
// Result register: sends a frame out one byte per item, MSB byte first.
// ----------------------------------------------------------------------------
`default_nettype none

module nff_byte_shifter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire nff_pkg::frame_t    frame,
  output      logic               free,
  output      logic               result_valid,
  input  wire logic               result_stall,
  output      nff_pkg::res_item_t result
);

  logic        full;
  logic [63:0] shreg;
  logic        tubes_on;
  logic [2:0]  idx;
  logic [2:0]  last_idx;
  logic        last;
  logic        send;

  assign last_idx = tubes_on ? nff_pkg::LAST_IDX_ON : nff_pkg::LAST_IDX_OFF;
  assign last     = idx == last_idx;
  assign send     = full & ~result_stall;
  assign free     = ~full | (send & last);

  // output item
  assign result_valid          = full;
  assign result.spi_byte       = shreg[nff_pkg::FRAME_BITS-1 -: 8];
  assign result.first_of_frame = idx == 3'd0;
  assign result.last_of_frame  = last;
  assign result.raise_enable   = last & tubes_on;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= '0;
    end else if (send) begin
      if (last) begin
        full <= 1'b0;
      end
      idx <= idx + 3'd1;
    end
  end

  // frame data
  always_ff @(posedge clk) begin
    if (load) begin
      shreg    <= frame.data;
      tubes_on <= frame.tubes_on;
    end else if (send) begin
      shreg <= {shreg[nff_pkg::FRAME_BITS-9:0], 8'd0};
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    full |-> idx <= last_idx) else $error("byte index past end of frame");
  a_load_restarts: assert property (@(posedge clk) disable iff (rst)
    load |=> full && idx == 3'd0) else $error("frame load did not restart");
  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    full |-> !(idx == 3'd0 && last)) else $error("frame of a single byte");

endmodule

`default_nettype wire

// ===== rtl/nixie_frame_formatter.sv =====
// ----------------------------------------------------------------------------
// nixie_frame_formatter
// Each accepted refresh request becomes a frame of bytes for the tube
// drivers: eight bytes (two 32-bit words, MSB byte first) with the tubes on,
// four zero bytes with them off, and nothing when the request comes sooner
// than frame_limit_us after the last frame. Bytes leave at one per cycle
// from the result register while result_stall is low, and the byte
// serialiser sets the sustained frame rate. A dropped request is taken from
// the input register without waiting for the serialiser. One request waits in
// the input register while the previous frame is still draining, and its
// frame is loaded in the cycle the last byte goes. A request passes through
// the input register, then the result register, before its first byte appears. The config port is always
// ready; write only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module nixie_frame_formatter (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                request_valid,
  output      logic                request_stall,
  input  wire nff_pkg::req_item_t  request,
  output      logic                result_valid,
  input  wire logic                result_stall,
  output      nff_pkg::res_item_t  result,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire nff_pkg::cfg_index_t cfg_index,
  input  wire logic [31:0]         cfg_data
);

  logic            full;
  nff_pkg::prep_t  prep;
  logic            take;
  logic            load;
  logic            free;
  nff_pkg::frame_t frame;

  assign cfg_ready = 1'b1;

  // input register
  nff_req_stage u_req (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .take          (take),
    .full          (full),
    .prep          (prep)
  );

  // frame build and state
  nff_frame_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .full      (full),
    .prep      (prep),
    .free      (free),
    .take      (take),
    .load      (load),
    .frame     (frame)
  );

  // byte output
  nff_byte_shifter u_shift (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .frame        (frame),
    .free         (free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== sim/nff_frame_checker.sv =====
// ----------------------------------------------------------------------------
// nff_frame_checker
// Watches the request, result and config channels of the nixie frame
// formatter. Keeps its own copy of the timing and blink state, turns every
// accepted request into the bytes it should produce and compares each
// accepted result byte, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nff_frame_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                request_valid,
  input  logic                request_stall,
  input  nff_pkg::req_item_t  request,
  input  logic                result_valid,
  input  logic                result_stall,
  input  nff_pkg::res_item_t  result,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  nff_pkg::cfg_index_t cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  mismatches,
  output int                  bytes_due
);

  // register copies
  logic [31:0] frame_limit;
  logic [15:0] blink_period;

  // timing and blink state
  logic [31:0] last_frame_us;
  logic [31:0] last_blink_ms;
  logic        blink_phase;
  logic [7:0]  dot_mask_hold;
  logic        lower_dot;
  logic        upper_dot;

  // bytes still owed by the block, oldest first
  nff_pkg::res_item_t frame_bytes_due[$];
  nff_pkg::res_item_t want;

  task automatic log_failure(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // one-hot tube code, blanked when the digit blinks off
  function automatic logic [9:0] tube_code(input int digit, input int pos,
                                           input logic blanking,
                                           input logic [7:0] mask);
    if (blanking && mask[pos])
      return '0;
    return 10'd1 << digit;
  endfunction

  // work out the bytes that one refresh request should give
  task automatic format_frame(input nff_pkg::req_item_t r);
    logic [31:0]        since_frame;
    logic [31:0]        since_blink;
    logic [63:0]        frame;
    logic [7:0]         lit_dots;
    logic               blinking;
    logic               blanking;
    int                 value;
    int                 digit[6];
    nff_pkg::res_item_t b;

    since_frame = r.now_us - last_frame_us;
    if (since_frame < frame_limit)
      return;
    last_frame_us = r.now_us;

    // tubes off: four zero bytes, blink state untouched
    if (!r.tubes_on) begin
      for (int k = 0; k < 4; k++) begin
        b.spi_byte       = '0;
        b.first_of_frame = (k == 0);
        b.last_of_frame  = (k == 3);
        b.raise_enable   = 1'b0;
        frame_bytes_due.push_back(b);
      end
      return;
    end

    // split into digits, position 0 is hour tens
    value = int'(r.display_value);
    for (int p = 5; p >= 0; p--) begin
      digit[p] = value % 10;
      value    = value / 10;
    end

    // blink phase and dot flags only move while editing
    blinking = r.blink_up & r.blink_down;
    if (blinking) begin
      since_blink = r.now_ms - last_blink_ms;
      if (since_blink > {16'd0, blink_period}) begin
        last_blink_ms = r.now_ms;
        blink_phase   = !blink_phase;
        dot_mask_hold = blink_phase ? 8'h00 : r.blink_mask;
      end
      lit_dots  = r.dot_pattern & ~dot_mask_hold;
      lower_dot = lit_dots[6];
      upper_dot = lit_dots[7];
    end
    blanking = blinking && blink_phase;

    frame = {upper_dot, lower_dot,
             tube_code(digit[5], 5, blanking, r.blink_mask),
             tube_code(digit[4], 4, blanking, r.blink_mask),
             tube_code(digit[3], 3, blanking, r.blink_mask),
             upper_dot, lower_dot,
             tube_code(digit[2], 2, blanking, r.blink_mask),
             tube_code(digit[1], 1, blanking, r.blink_mask),
             tube_code(digit[0], 0, blanking, r.blink_mask)};

    // msb byte of the seconds word first
    for (int k = 0; k < 8; k++) begin
      b.spi_byte       = frame[63 - 8 * k -: 8];
      b.first_of_frame = (k == 0);
      b.last_of_frame  = (k == 7);
      b.raise_enable   = (k == 7);
      frame_bytes_due.push_back(b);
    end
  endtask

  // sample every channel at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      frame_limit   = nff_pkg::FRAME_LIMIT_RESET;
      blink_period  = nff_pkg::BLINK_PERIOD_RESET;
      last_frame_us = '0;
      last_blink_ms = '0;
      blink_phase   = 1'b0;
      dot_mask_hold = '0;
      lower_dot     = 1'b0;
      upper_dot     = 1'b0;
      mismatches    = 0;
      frame_bytes_due.delete();
      bytes_due    <= 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nff_pkg::REG_FRAME_LIMIT:  frame_limit  = cfg_data;
          nff_pkg::REG_BLINK_PERIOD: blink_period = cfg_data[15:0];
          default: ;
        endcase
      end

      // result bytes against the oldest one due
      if (result_valid && !result_stall) begin
        if (frame_bytes_due.size() == 0) begin
          log_failure($sformatf("byte %02h with nothing due", result.spi_byte));
        end else begin
          want = frame_bytes_due.pop_front();
          if (result.spi_byte !== want.spi_byte)
            log_failure($sformatf("spi_byte %02h, want %02h",
                                  result.spi_byte, want.spi_byte));
          if (result.first_of_frame !== want.first_of_frame)
            log_failure($sformatf("first_of_frame %b, want %b",
                                  result.first_of_frame, want.first_of_frame));
          if (result.last_of_frame !== want.last_of_frame)
            log_failure($sformatf("last_of_frame %b, want %b",
                                  result.last_of_frame, want.last_of_frame));
          if (result.raise_enable !== want.raise_enable)
            log_failure($sformatf("raise_enable %b, want %b",
                                  result.raise_enable, want.raise_enable));
        end
      end

      // new request item
      if (request_valid && !request_stall)
        format_frame(request);

      bytes_due <= frame_bytes_due.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives refresh requests and register writes into the nixie frame
// formatter: a directed run over the timing, wrap, blanking and dot cases,
// then random requests under three register settings and three stall mixes.
// The frame checker beside the block does the comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 132;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                request_valid = 1'b0;
  logic                request_stall;
  nff_pkg::req_item_t  request       = '0;
  logic                result_valid;
  logic                result_stall  = 1'b0;
  nff_pkg::res_item_t  result;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  nff_pkg::cfg_index_t cfg_index     = nff_pkg::REG_FRAME_LIMIT;
  logic [31:0]         cfg_data      = '0;

  int          mismatches;
  int          bytes_due;
  int          send_idle_pct = 33;
  int          take_idle_pct = 54;
  int          quiet_cycles  = 0;
  logic [31:0] limit_now     = nff_pkg::FRAME_LIMIT_RESET;
  logic [15:0] period_now    = nff_pkg::BLINK_PERIOD_RESET;
  logic [31:0] clock_us;
  logic [31:0] clock_ms;

  nixie_frame_formatter i_dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  nff_frame_checker i_frame_check (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .bytes_due     (bytes_due)
  );

  always #5 clk = ~clk;

  // receiver stalls
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < take_idle_pct);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (request_valid && !request_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request item, with a random gap in front
  task automatic send_request(input nff_pkg::req_item_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      request_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    request_valid <= 1'b1;
    request       <= r;
    do @(posedge clk); while (request_stall);
  endtask

  task automatic send_fields(input logic [31:0] us, input logic [31:0] ms,
                             input logic [19:0] value, input logic tubes,
                             input logic up, input logic down,
                             input logic [7:0] mask, input logic [7:0] dots);
    nff_pkg::req_item_t r;
    r.now_us        = us;
    r.now_ms        = ms;
    r.display_value = value;
    r.tubes_on      = tubes;
    r.blink_up      = up;
    r.blink_down    = down;
    r.blink_mask    = mask;
    r.dot_pattern   = dots;
    send_request(r);
  endtask

  // let every owed byte out, then give a dropped request time to clear
  task automatic wait_quiet();
    request_valid <= 1'b0;
    do @(posedge clk); while (bytes_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input nff_pkg::cfg_index_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // both registers, written only once the block has gone idle
  task automatic set_config(input logic [31:0] limit, input logic [15:0] period);
    wait_quiet();
    limit_now  = limit;
    period_now = period;
    write_reg(nff_pkg::REG_FRAME_LIMIT, limit);
    // upper half of the blink write is junk the block must drop
    write_reg(nff_pkg::REG_BLINK_PERIOD, {16'($urandom), period});
    cfg_valid <= 1'b0;
  endtask

  // random requests, mostly spaced past the frame limit
  task automatic run_random(input int count);
    nff_pkg::req_item_t r;
    int                 sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 70)
        clock_us += limit_now + $urandom_range(64);
      else if (sel < 90)
        clock_us += (limit_now == 0) ? 32'd0 : $urandom_range(limit_now - 1, 0);
      else
        clock_us = $urandom;
      if ($urandom_range(99) < 80)
        clock_ms += $urandom_range(2 * period_now + 2, 0);
      else
        clock_ms = $urandom;

      sel = $urandom_range(99);
      if (sel < 75)
        r.display_value = 20'($urandom_range(999999, 0));
      else if (sel < 90)
        r.display_value = 20'($urandom_range(20'hFFFFF, 0));
      else if (sel < 94)
        r.display_value = 20'd999999;
      else if (sel < 97)
        r.display_value = 20'hFFFFF;
      else
        r.display_value = '0;

      r.now_us      = clock_us;
      r.now_ms      = clock_ms;
      r.tubes_on    = ($urandom_range(99) < 85);
      r.blink_up    = ($urandom_range(99) < 75);
      r.blink_down  = ($urandom_range(99) < 75);
      r.blink_mask  = 8'($urandom);
      r.dot_pattern = 8'($urandom);
      send_request(r);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    send_fields(32'd0, 32'd0, 20'd123456, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00);
    send_fields(32'd4999, 32'd5, 20'd123456, 1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF);
    // tubes off with editing on: zero bytes, blink state held
    send_fields(32'd5000, 32'd10, 20'd654321, 1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF);
    send_fields(32'd10000, 32'd20, 20'd0, 1'b1, 1'b0, 1'b0, 8'h00, 8'hFF);
    send_fields(32'd15000, 32'd30, 20'd999999, 1'b1, 1'b0, 1'b0, 8'hFF, 8'hFF);
    send_fields(32'd20000, 32'd40, 20'hFFFFF, 1'b1, 1'b0, 1'b0, 8'hFF, 8'hFF);
    // phase turns on, every digit blanks
    send_fields(32'd25000, 32'd301, 20'd123456, 1'b1, 1'b1, 1'b1, 8'hFF, 8'hC0);
    // exactly the period: no toggle
    send_fields(32'd30000, 32'd601, 20'd654321, 1'b1, 1'b1, 1'b1, 8'h2A, 8'hC0);
    // phase turns off, held mask hides the lower dots
    send_fields(32'd35000, 32'd602, 20'd135790, 1'b1, 1'b1, 1'b1, 8'h40, 8'hC0);
    // one enable only: dots keep their last value
    send_fields(32'd40000, 32'd1000, 20'd246802, 1'b1, 1'b1, 1'b0, 8'hFF, 8'h00);
    send_fields(32'd45000, 32'd2000, 20'd111111, 1'b1, 1'b0, 1'b1, 8'hFF, 8'hFF);
    send_fields(32'd50000, 32'd2000, 20'd222222, 1'b0, 1'b1, 1'b1, 8'hFF, 8'h00);
    // mask bits above the digits touch only the dots
    send_fields(32'd55000, 32'd2302, 20'd333333, 1'b1, 1'b1, 1'b1, 8'h80, 8'h80);
    send_fields(32'd60000, 32'd2700, 20'd444444, 1'b1, 1'b1, 1'b1, 8'h80, 8'hC0);
    // both clocks wrap
    send_fields(32'hFFFF_F000, 32'hFFFF_FFFF, 20'd987654, 1'b1, 1'b1, 1'b1, 8'h3F, 8'hFF);
    send_fields(32'h0000_0400, 32'h0000_0200, 20'd555555, 1'b1, 1'b1, 1'b1, 8'h15, 8'h7F);
    send_fields(32'h0000_1000, 32'h0000_0300, 20'd555555, 1'b1, 1'b1, 1'b1, 8'h15, 8'h7F);

    // largest limit: only a full wrap minus one gets through
    set_config(32'hFFFF_FFFF, 16'hFFFF);
    send_fields(32'h0000_0400, 32'h0001_0000, 20'd765432, 1'b1, 1'b1, 1'b1, 8'h01, 8'hFF);
    send_fields(32'h0000_03FF, 32'h0001_0300, 20'd765432, 1'b1, 1'b1, 1'b1, 8'h01, 8'hFF);
    send_fields(32'h0000_0400, 32'h0001_0400, 20'd765432, 1'b1, 1'b1, 1'b1, 8'h01, 8'hFF);

    // zero limit and zero period
    set_config(32'd0, 16'd0);
    send_fields(32'h0000_03FF, 32'h0001_0300, 20'd101010, 1'b1, 1'b1, 1'b1, 8'h3F, 8'hC0);
    send_fields(32'h0000_03FF, 32'h0001_0301, 20'd101010, 1'b1, 1'b1, 1'b1, 8'h3F, 8'hC0);
    send_fields(32'd0, 32'd0, 20'd0, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00);
    send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF);

    // random, sender idles less than receiver
    clock_us = $urandom;
    clock_ms = $urandom;
    set_config(32'd37, 16'd5);
    run_random(RANDOM_ITEMS);

    // random, receiver idles less than sender
    set_config(32'd0, 16'd0);
    send_idle_pct = 54;
    take_idle_pct = 33;
    run_random(RANDOM_ITEMS);

    // random, no idling on either side
    set_config(32'd2500, 16'hFFFF);
    send_idle_pct = 0;
    take_idle_pct = 0;
    run_random(RANDOM_ITEMS);

    wait_quiet();
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
